// ===== rtl/lr_pkg.sv =====
`default_nettype none

package lr_pkg;

  // Fixed widths of the frame-side fields.
  localparam int ADDR_W   = 24;
  localparam int PITCH_W  = 13;
  localparam int COLOUR_W = 8;

  // Row pitch after reset.
  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd2200;

  // Item operation codes.
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } lr_op_t;

endpackage

`default_nettype wire

// ===== rtl/lr_if.sv =====
`default_nettype none

// Command channel: start a line or request the next pixel.
interface lr_in_if
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  lr_op_t                operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOUR_W-1:0]   colour;

  modport source (
    output valid, operation, start_x, start_y, end_x, end_y, colour,
    input  ready
  );
  modport sink (
    input  valid, operation, start_x, start_y, end_x, end_y, colour,
    output ready
  );
endinterface

// Pixel channel towards the frame buffer.
interface lr_out_if
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [ADDR_W-1:0]     pixel_address;
  logic [COLOUR_W-1:0]   pixel_colour;
  logic                  last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_address, pixel_colour, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_address, pixel_colour, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lr_in_reg.sv =====
`default_nettype none

module lr_in_reg
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lr_in_if.sink     in_chan,
  lr_in_if.source   item_chan
);

  logic                  valid_r, valid_nxt;
  lr_op_t                operation_r;
  logic [COORD_BITS-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [COLOUR_W-1:0]   colour_r;
  logic                  load;

  // The register takes a new item whenever it is empty or is being drained.
  assign in_chan.ready = !valid_r || item_chan.ready;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture on every input transfer.
  always_ff @(posedge clk) begin
    if (load) begin
      operation_r <= in_chan.operation;
      start_x_r   <= in_chan.start_x;
      start_y_r   <= in_chan.start_y;
      end_x_r     <= in_chan.end_x;
      end_y_r     <= in_chan.end_y;
      colour_r    <= in_chan.colour;
    end
  end

  assign item_chan.valid     = valid_r;
  assign item_chan.operation = operation_r;
  assign item_chan.start_x   = start_x_r;
  assign item_chan.start_y   = start_y_r;
  assign item_chan.end_x     = end_x_r;
  assign item_chan.end_y     = end_y_r;
  assign item_chan.colour    = colour_r;

endmodule

`default_nettype wire

// ===== rtl/lr_core.sv =====
`default_nettype none

module lr_core
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [PITCH_W-1:0] cfg_wdata,
  lr_in_if.sink                   item_chan,
  lr_out_if.source                out_chan
);

  localparam int EW      = COORD_BITS + 2;
  localparam int PROD_W  = COORD_BITS + PITCH_W + 1;
  localparam int FULL_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

  // Line state.
  logic [PITCH_W-1:0]    pitch_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic                  x_down_r, x_down_nxt, y_down_r, y_down_nxt;
  logic                  x_major_r, x_major_nxt, drawing_r, drawing_nxt;
  logic [COLOUR_W-1:0]   colour_r, colour_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic                  last_nxt;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [ADDR_W-1:0]     paddr_r;
  logic [COLOUR_W-1:0]   pcolour_r;
  logic                  plast_r;

  // Working values.
  logic                  fire, is_start, has_result;
  logic [COORD_BITS-1:0] st_dx, st_dy;
  logic [FULL_W-1:0]     st_addr_full;
  logic [COORD_BITS-1:0] minor, major;
  logic signed [EW-1:0]  err_sum;
  logic                  take, step_x, step_y;
  logic [ADDR_W-1:0]     pitch_ext, x_inc, y_inc;

  // An idle tick is dropped even while the result register is blocked.
  assign is_start       = (item_chan.operation == OP_START);
  assign has_result     = is_start || drawing_r;
  assign item_chan.ready = !out_valid_r || out_chan.ready || !has_result;
  assign fire           = item_chan.valid && item_chan.ready;

  // Start set-up: deltas, directions and the first address.
  always_comb begin
    st_dx = (item_chan.end_x >= item_chan.start_x) ?
            item_chan.end_x - item_chan.start_x : item_chan.start_x - item_chan.end_x;
    st_dy = (item_chan.end_y >= item_chan.start_y) ?
            item_chan.end_y - item_chan.start_y : item_chan.start_y - item_chan.end_y;
    st_addr_full = FULL_W'(item_chan.start_y) * FULL_W'(pitch_r)
                 + FULL_W'(item_chan.start_x);
  end

  // One Bresenham step: error update, axis steps and address increment.
  always_comb begin
    minor     = x_major_r ? dy_r : dx_r;
    major     = x_major_r ? dx_r : dy_r;
    err_sum   = err_r + $signed({2'b00, minor});
    take      = (err_sum > $signed(EW'(0)));
    step_x    = x_major_r || take;
    step_y    = !x_major_r || take;
    pitch_ext = ADDR_W'(pitch_r);
    x_inc     = step_x ? (x_down_r ? {ADDR_W{1'b1}} : ADDR_W'(1)) : '0;
    y_inc     = step_y ? (y_down_r ? -pitch_ext : pitch_ext) : '0;
  end

  // Next line state.
  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    tgt_x_nxt   = tgt_x_r;
    tgt_y_nxt   = tgt_y_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    err_nxt     = err_r;
    x_down_nxt  = x_down_r;
    y_down_nxt  = y_down_r;
    x_major_nxt = x_major_r;
    drawing_nxt = drawing_r;
    colour_nxt  = colour_r;
    addr_nxt    = addr_r;
    last_nxt    = 1'b0;
    if (is_start) begin
      cur_x_nxt   = item_chan.start_x;
      cur_y_nxt   = item_chan.start_y;
      tgt_x_nxt   = item_chan.end_x;
      tgt_y_nxt   = item_chan.end_y;
      dx_nxt      = st_dx;
      dy_nxt      = st_dy;
      err_nxt     = '0;
      x_down_nxt  = (item_chan.end_x <= item_chan.start_x);
      y_down_nxt  = (item_chan.end_y < item_chan.start_y);
      x_major_nxt = (st_dy <= st_dx);
      colour_nxt  = item_chan.colour;
      addr_nxt    = st_addr_full[ADDR_W-1:0];
      last_nxt    = (item_chan.start_x == item_chan.end_x) &&
                    (item_chan.start_y == item_chan.end_y);
      drawing_nxt = !last_nxt;
    end else if (drawing_r) begin
      err_nxt   = take ? err_sum - $signed({2'b00, major}) : err_sum;
      cur_x_nxt = step_x ? (x_down_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1))
                         : cur_x_r;
      cur_y_nxt = step_y ? (y_down_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1))
                         : cur_y_r;
      addr_nxt  = addr_r + x_inc + y_inc;
      last_nxt  = (cur_x_nxt == tgt_x_r) && (cur_y_nxt == tgt_y_r);
      drawing_nxt = !last_nxt;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r     <= PITCH_RESET;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      err_r       <= '0;
      x_down_r    <= 1'b0;
      y_down_r    <= 1'b0;
      x_major_r   <= 1'b0;
      drawing_r   <= 1'b0;
      colour_r    <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pitch_r <= cfg_wdata;
      end
      if (fire) begin
        cur_x_r   <= cur_x_nxt;
        cur_y_r   <= cur_y_nxt;
        tgt_x_r   <= tgt_x_nxt;
        tgt_y_r   <= tgt_y_nxt;
        dx_r      <= dx_nxt;
        dy_r      <= dy_nxt;
        err_r     <= err_nxt;
        x_down_r  <= x_down_nxt;
        y_down_r  <= y_down_nxt;
        x_major_r <= x_major_nxt;
        drawing_r <= drawing_nxt;
        colour_r  <= colour_nxt;
        addr_r    <= addr_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pixel payload, loaded with the same values the state takes.
  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      px_r      <= cur_x_nxt;
      py_r      <= cur_y_nxt;
      paddr_r   <= addr_nxt;
      pcolour_r <= colour_nxt;
      plast_r   <= last_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pixel_x       = px_r;
  assign out_chan.pixel_y       = py_r;
  assign out_chan.pixel_address = paddr_r;
  assign out_chan.pixel_colour  = pcolour_r;
  assign out_chan.last_pixel    = plast_r;

endmodule

`default_nettype wire

// ===== rtl/line_rasterizer.sv =====
// Line rasterizer: turns line commands into a stream of frame-buffer pixels.
// in_chan carries commands. A start command (operation OP_START) gives two end
// points and a colour and produces the start pixel; each tick command
// (OP_TICK) produces the next pixel of the line. A tick with no line in
// progress is consumed and produces nothing. The pixel that reaches the end
// point has last_pixel set; a line whose end points coincide gives one pixel.
// out_chan carries pixels with coordinates, linear address and colour.
// cfg_we/cfg_wdata set the row pitch used for addresses; write it while idle.
// A command passes from the input register through the step logic into the
// result register, which drives out_chan. Throughput is one command per cycle
// while out_chan does not stall; the error and address update of the step
// unit is combinational, and the start address uses one multiply. Reset
// clears the line state, empties both registers and sets the pitch to 2200.
// When the receiver stalls the pixel is held, one more command waits in the
// input register, and in_chan.ready then falls until the pixel is taken.
`default_nettype none

module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  lr_in_if.sink                   in_chan,
  lr_out_if.source                out_chan,
  input  wire logic               cfg_we,
  input  wire logic [PITCH_W-1:0] cfg_wdata
);

  lr_in_if #(.COORD_BITS(COORD_BITS)) item_chan ();

  lr_in_reg #(.COORD_BITS(COORD_BITS)) u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .item_chan (item_chan.source)
  );

  lr_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_chan (item_chan.sink),
    .out_chan  (out_chan)
  );

  // Back-pressure only reaches the command side through a blocked pixel.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("command side stalled without a blocked pixel");

  // A command transfer always lands in the input register.
  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> item_chan.valid)
    else $error("accepted command lost before the step logic");

  // A start command taken by the step logic always yields a pixel.
  a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (item_chan.valid && item_chan.ready && (item_chan.operation == OP_START))
    |=> out_chan.valid)
    else $error("start command produced no pixel");

endmodule

`default_nettype wire
